// ===== rtl/array_list_engine_top_macros.svh =====
// assertion macros used by the array list engine checker
`ifndef ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`define ARRAY_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication, sampled on the block clock, quiet in reset
`define ALE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the block clock, quiet in reset
`define ALE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ale_pkg.sv =====
// shared types, widths and codes for the array list engine
`default_nettype none

package ale_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned LENGTH_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SORTED = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

  localparam logic [INDEX_W-1:0] INDEX_NONE = '1;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic cmp_en;
    logic sorted;
    logic ins;
    logic del;
  } ale_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ale_cell.sv =====
// one list entry: holds a word, compares it and shifts with its neighbours
`default_nettype none

module ale_cell import ale_pkg::*; #(
  parameter int unsigned CNT_W    = 5,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                      clk_i,
  input  wire ale_ctrl_t                 ctrl_i,
  input  wire logic [CNT_W-1:0]          tgt_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire logic signed [VALUE_W-1:0] left_i,
  input  wire logic signed [VALUE_W-1:0] right_i,
  output logic signed [VALUE_W-1:0]      entry_o,
  output logic                           hit_o
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

  logic signed [VALUE_W-1:0] entry_q, entry_d;
  logic                      hit_q, hit_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (MY_IDX == tgt_i) begin
        entry_d = value_i;
      end else if (MY_IDX > tgt_i) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (MY_IDX >= tgt_i) begin
        entry_d = right_i;
      end
    end
  end

  // sorted insert flags every entry not below the value, locate every equal entry
  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.cmp_en) begin
      if (ctrl_i.sorted) begin
        hit_d = !(entry_q < value_i);
      end else begin
        hit_d = (entry_q == value_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

// ===== rtl/array_list_engine_top.sv =====
// array list engine: bounded ordered list in a row of shifting cells
`default_nettype none

// Bounded list of signed 32-bit words, CAPACITY entries, one cell per entry.
// An item is taken when start is high and busy is low; its result is registered
// and appears in the cycle after the work ends, for one cycle with done_o high,
// and must be taken then. Insert, delete and every refused request go straight
// to the apply state; no new item is taken until the block is idle again.
// Locate and an accepted sorted insert first latch a compare flag in every cell,
// then scan the flags one entry per cycle from index 0 until the first hit or the
// end of the list, then apply. The scan is the limiting path.

module array_list_engine_top import ale_pkg::*; #(
  parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [FUNC_W-1:0]          func_i,
  input  wire logic signed [VALUE_W-1:0]  value_i,
  input  wire logic [POS_W-1:0]           position_i,
  output logic                            done_o,
  output logic [STATUS_W-1:0]             status_o,
  output logic signed [INDEX_W-1:0]       index_o,
  output logic [LENGTH_W-1:0]             length_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [FUNC_W-1:0]         func_q, func_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [CW-1:0]             tgt_q, tgt_d;
  logic [STATUS_W-1:0]       stat_q, stat_d;
  logic [CW-1:0]             count_q, count_d;

  logic                      done_q, done_d;
  logic [STATUS_W-1:0]       status_q, status_d;
  logic [INDEX_W-1:0]        index_q, index_d;
  logic [LENGTH_W-1:0]       length_q, length_d;

  logic                      full;
  logic [CMPW-1:0]           pos_ext, cnt_ext;
  logic                      write_ok;
  logic                      not_found;
  ale_ctrl_t                 ctrl;

  logic signed [VALUE_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]       hit_w;

  assign full    = (count_q == CW'(CAPACITY));
  assign pos_ext = CMPW'(position_i);
  assign cnt_ext = CMPW'(count_q);

  assign write_ok  = (state_q == S_APPLY) && (stat_q == STATUS_OK) &&
                     (func_q != FUNC_LOCATE);
  assign not_found = (func_q == FUNC_LOCATE) && (tgt_q == count_q);

  always_comb begin
    ctrl.cmp_en = (state_q == S_CMP);
    ctrl.sorted = (func_q == FUNC_SORTED);
    ctrl.ins    = write_ok && (func_q inside {FUNC_INSERT, FUNC_SORTED});
    ctrl.del    = write_ok && (func_q == FUNC_DELETE);
  end

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    value_d  = value_q;
    tgt_d    = tgt_q;
    stat_d   = stat_q;
    count_d  = count_q;
    done_d   = 1'b0;
    status_d = status_q;
    index_d  = index_q;
    length_d = length_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d  = func_i;
          value_d = value_i;
          tgt_d   = '0;
          stat_d  = STATUS_OK;
          state_d = S_APPLY;
          case (func_i)
            FUNC_INSERT: begin
              tgt_d = CW'(position_i);
              if (pos_ext > cnt_ext) begin
                stat_d = STATUS_BADPOS;
              end else if (full) begin
                stat_d = STATUS_FULL;
              end
            end
            FUNC_DELETE: begin
              tgt_d = CW'(position_i);
              if (pos_ext >= cnt_ext) begin
                stat_d = STATUS_BADPOS;
              end
            end
            FUNC_LOCATE: begin
              state_d = S_CMP;
            end
            default: begin
              if (full) begin
                stat_d = STATUS_FULL;
              end else begin
                state_d = S_CMP;
              end
            end
          endcase
        end
      end
      S_CMP: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // end of list is tested first, so the flag read past it is ignored
        if ((tgt_q == count_q) || hit_w[tgt_q[IW-1:0]]) begin
          state_d = S_APPLY;
        end else begin
          tgt_d = tgt_q + 1'b1;
        end
      end
      S_APPLY: begin
        if (ctrl.ins) begin
          count_d = count_q + 1'b1;
        end else if (ctrl.del) begin
          count_d = count_q - 1'b1;
        end
        done_d   = 1'b1;
        status_d = stat_q;
        if ((stat_q != STATUS_OK) || not_found) begin
          index_d = INDEX_NONE;
        end else begin
          index_d = INDEX_W'(tgt_q);
        end
        length_d = LENGTH_W'(count_d);
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
      index_q  <= '0;
      length_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
      index_q  <= index_d;
      length_q <= length_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    value_q <= value_d;
    tgt_q   <= tgt_d;
    stat_q  <= stat_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = value_q;
    end else begin : g_left
      assign left_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = entry_w[i];
    end else begin : g_right
      assign right_w = entry_w[i+1];
    end
    ale_cell #(
      .CNT_W    (CW),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .tgt_i   (tgt_q),
      .value_i (value_q),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[i]),
      .hit_o   (hit_w[i])
    );
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign index_o  = index_q;
  assign length_o = length_q;

endmodule

`default_nettype wire

// ===== rtl/ale_checker.sv =====
// port-level checks for the array list engine, bound to the top level
`default_nettype none

`include "array_list_engine_top_macros.svh"

module ale_checker import ale_pkg::*; (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      done_o,
  input wire logic [STATUS_W-1:0]       status_o,
  input wire logic signed [INDEX_W-1:0] index_o,
  input wire logic [LENGTH_W-1:0]       length_o
);

  `ALE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "item taken but block not busy")

  `ALE_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start), "busy rose without an item")

  `ALE_ASSERT_IMP(a_done_idle, done_o, !busy, "result shown while still busy")

  `ALE_ASSERT_IMP(a_refused_idx, done_o && (status_o != STATUS_OK),
                  index_o == INDEX_NONE, "refused item without index of -1")

  `ALE_ASSERT_IMP(a_len_moves, !$stable(length_o), done_o, "length moved without a result")

endmodule

bind array_list_engine_top ale_checker u_ale_checker (.*);

`default_nettype wire

// ===== test/array_list_engine_top_tb.sv =====
// self-checking testbench for the bounded array list engine
`timescale 1ns / 1ps

module array_list_engine_top_tb;
  import ale_pkg::*;

  localparam int unsigned CAPACITY = DEFAULT_CAPACITY;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 400;
  localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0] position;
    int gap;
    bit hold;
  } list_request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0] index;
    logic [LENGTH_W-1:0] length;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] func_i = '0;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic [POS_W-1:0] position_i = '0;
  logic done_o;
  logic [STATUS_W-1:0] status_o;
  logic signed [INDEX_W-1:0] index_o;
  logic [LENGTH_W-1:0] length_o;

  list_request_t pending_requests[$];
  list_result_t expected_results[$];
  int gap_count = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int cycle_count = 0;
  int total_items;

  // shadow of the list as the block should hold it
  logic signed [VALUE_W-1:0] list_words[CAPACITY];
  int list_len = 0;

  // stimulus planning: element count and values likely to be present
  int plan_len = 0;
  logic signed [VALUE_W-1:0] value_pool[$];

  array_list_engine_top #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .func_i(func_i),
    .value_i(value_i),
    .position_i(position_i),
    .done_o(done_o),
    .status_o(status_o),
    .index_o(index_o),
    .length_o(length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    n_errors++;
  endtask

  function automatic void open_slot(input int slot, input logic signed [VALUE_W-1:0] word);
    for (int i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
    list_words[slot] = word;
    list_len++;
  endfunction

  function automatic list_result_t apply_request(input logic [FUNC_W-1:0] func,
                                                 input logic signed [VALUE_W-1:0] word,
                                                 input logic [POS_W-1:0] position);
    list_result_t res;
    int slot;
    bit hit;
    res.status = STATUS_OK;
    res.index = INDEX_NONE;
    slot = int'(position);
    hit = 1'b0;
    case (func)
      FUNC_INSERT: begin
        // a bad position wins over a full list
        if (slot > list_len) begin
          res.status = STATUS_BADPOS;
        end else if (list_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          open_slot(slot, word);
          res.index = INDEX_W'(slot);
        end
      end
      FUNC_DELETE: begin
        if (slot >= list_len) begin
          res.status = STATUS_BADPOS;
        end else begin
          for (int i = slot; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          res.index = INDEX_W'(slot);
        end
      end
      FUNC_LOCATE: begin
        for (int i = 0; i < list_len; i++) begin
          if (!hit && list_words[i] == word) begin
            hit = 1'b1;
            res.index = INDEX_W'(i);
          end
        end
      end
      default: begin
        if (list_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          slot = 0;
          while (slot < list_len && list_words[slot] < word) slot++;
          open_slot(slot, word);
          res.index = INDEX_W'(slot);
        end
      end
    endcase
    res.length = LENGTH_W'(list_len);
    return res;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return ($urandom_range(0, 1) != 0) ? '0 : '1;
      3, 4, 5: return VALUE_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_search_value();
    if (value_pool.size() != 0 && $urandom_range(0, 9) < 7)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    return pick_value();
  endfunction

  function automatic void add_item(input logic [FUNC_W-1:0] func,
                                   input logic signed [VALUE_W-1:0] word,
                                   input logic [POS_W-1:0] position,
                                   input int gap, input bit hold);
    list_request_t req;
    req.func = func;
    req.value = word;
    req.position = position;
    req.gap = gap;
    req.hold = hold;
    pending_requests.push_back(req);
    // keep the planned count in step so positions can be aimed at the list
    case (func)
      FUNC_INSERT: if (int'(position) <= plan_len && plan_len < CAPACITY) plan_len++;
      FUNC_DELETE: if (int'(position) < plan_len) plan_len--;
      FUNC_SORTED: if (plan_len < CAPACITY) plan_len++;
      default: ;
    endcase
    if (func == FUNC_INSERT || func == FUNC_SORTED) begin
      value_pool.push_back(word);
      if (value_pool.size() > 32) void'(value_pool.pop_front());
    end
  endfunction

  // driver: holds start until the item is taken, then moves to the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      func_i <= '0;
      value_i <= '0;
      position_i <= '0;
      gap_count <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_request(func_i, value_i, position_i));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (pending_requests.size() == 0) begin
          start <= 1'b0;
        end else if (gap_count < pending_requests[0].gap) begin
          start <= 1'b0;
          gap_count <= gap_count + 1;
        end else if (pending_requests[0].hold && expected_results.size() != 0) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          func_i <= pending_requests[0].func;
          value_i <= pending_requests[0].value;
          position_i <= pending_requests[0].position;
          gap_count <= 0;
          void'(pending_requests.pop_front());
        end
      end
    end
  end

  // monitor: every strobed result is matched against the oldest prediction
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d index %0d length %0d",
                                  status_o, index_o, length_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (index_o !== want.index)
          report_mismatch($sformatf("index %0d, expected %0d", index_o, $signed(want.index)));
        if (length_o !== want.length)
          report_mismatch($sformatf("length %0d, expected %0d", length_o, want.length));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int roll;
    int phase;
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0] position;
    bit quiet;

    // directed: empty list, extremes, end of list, bad positions
    add_item(FUNC_LOCATE, '0, '0, 0, 1'b0);
    add_item(FUNC_DELETE, '0, '0, 0, 1'b0);
    add_item(FUNC_INSERT, '0, 5'd1, 1, 1'b0);
    add_item(FUNC_INSERT, WORD_MAX, '0, 0, 1'b0);
    add_item(FUNC_INSERT, WORD_MIN, '0, 0, 1'b0);
    add_item(FUNC_SORTED, '0, '1, 0, 1'b0);
    add_item(FUNC_SORTED, '1, '0, 2, 1'b0);
    add_item(FUNC_INSERT, 32'sd1, 5'd4, 0, 1'b0);
    add_item(FUNC_LOCATE, WORD_MAX, '0, 0, 1'b0);
    add_item(FUNC_LOCATE, 32'sd12345, '1, 0, 1'b0);
    add_item(FUNC_DELETE, '0, 5'd5, 0, 1'b0);
    add_item(FUNC_DELETE, '0, '0, 1, 1'b0);
    // fill up, then refused requests on a full list
    add_item(FUNC_SORTED, pick_value(), '0, 0, 1'b1);
    while (plan_len < CAPACITY) add_item(FUNC_SORTED, pick_value(), '0, 0, 1'b0);
    add_item(FUNC_INSERT, WORD_MIN, '0, 0, 1'b0);
    add_item(FUNC_SORTED, WORD_MAX, '0, 0, 1'b0);
    add_item(FUNC_INSERT, '0, 5'd17, 0, 1'b0);

    // random: alternating grow, mixed, shrink and back-to-back stretches
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 40) % 4;
      quiet = (phase == 3);
      roll = $urandom_range(0, 99);
      case (phase)
        0: func = (roll < 40) ? FUNC_INSERT : (roll < 75) ? FUNC_SORTED :
                  (roll < 85) ? FUNC_DELETE : FUNC_LOCATE;
        2: func = (roll < 55) ? FUNC_DELETE : (roll < 65) ? FUNC_INSERT :
                  (roll < 75) ? FUNC_SORTED : FUNC_LOCATE;
        default: func = FUNC_W'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 9) == 0 || func == FUNC_LOCATE || func == FUNC_SORTED)
        position = POS_W'($urandom_range(0, 31));
      else if (func == FUNC_INSERT)
        position = POS_W'($urandom_range(0, plan_len));
      else
        position = POS_W'((plan_len == 0) ? 0 : $urandom_range(0, plan_len - 1));
      add_item(func, (func == FUNC_LOCATE) ? pick_search_value() : pick_value(), position,
               pick_gap(quiet), n == 0 || $urandom_range(0, 49) == 0);
    end
    total_items = pending_requests.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < total_items) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    // stray results would show up within a scan of the whole list
    repeat (CAPACITY + 8) @(posedge clk_i);

    if (n_errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
